// File: rtl/core/crcfac_pkg.sv
// shared types, constants and crc byte update for the crc-32 framer
`default_nettype none

package crcfac_pkg;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BAD   = 2'd1,
    STAT_SHORT = 2'd2
  } frame_status_t;

  // reflected crc-32, one byte in, lsb first
  function automatic logic [31:0] crc_feed(input logic [31:0] crc_in,
                                           input logic [7:0] byte_in);
    logic [31:0] c;
    c = crc_in ^ {24'd0, byte_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/crc32_frame_append_check.sv
// crc-32 frame append / check block with registered request output
// a request's first output is registered and shows in the cycle after acceptance, but a
//   byte held in check mode leaves later; one byte per cycle while out_ready is high; a
//   final byte holds input until its crc trailer is out, or in check mode with payload
//   its status; rst (sync, active high) clears mode to append, crc to all ones, delay
//   line and byte count to zero, and drops any pending output
`default_nettype none

module crc32_frame_append_check
  import crcfac_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  // input requests
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  // output requests
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            out_last,
  output logic [1:0]      frame_status
);

  // mode and frame state
  logic        check_mode;
  logic [31:0] crc;
  logic [7:0]  delay [4];
  logic [2:0]  count;

  // pending results behind the output register
  // append: up to four crc bytes taken from the top of pend_word
  // check: one status request
  logic [2:0]  pend_cnt;
  logic        pend_is_stat;
  logic [31:0] pend_word;
  logic [1:0]  pend_status;

  logic out_free;
  logic accept;
  logic pend_pop;

  assign out_free = !out_valid || out_ready;
  // a new request is taken only once all extra results of the previous one are out
  assign in_ready = (pend_cnt == 3'd0) && out_free;
  assign accept   = in_valid && in_ready;
  assign pend_pop = (pend_cnt != 3'd0) && out_free;

  // append path: crc over the incoming byte
  logic [31:0] crc_app;
  logic [31:0] crc_fin;
  assign crc_app = crc_feed(crc, data_byte);
  assign crc_fin = ~crc_app;

  // check path: the oldest delay byte leaves as payload once four are held
  logic        full;
  logic [31:0] crc_chk;
  logic        too_short;
  logic [31:0] rx_trailer;
  logic [1:0]  chk_status;
  logic [2:0]  count_next;

  assign full       = (count == 3'd4);
  assign crc_chk    = full ? crc_feed(crc, delay[0]) : crc;
  // fewer than four bytes after this one is shifted in
  assign too_short  = (count < 3'd3);
  assign rx_trailer = {delay[1], delay[2], delay[3], data_byte};
  assign count_next = full ? count : count + 3'd1;

  always_comb begin
    if (too_short) begin
      chk_status = STAT_SHORT;
    end else if (rx_trailer == ~crc_chk) begin
      chk_status = STAT_OK;
    end else begin
      chk_status = STAT_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode   <= 1'b0;
      crc          <= CRC_INIT;
      delay        <= '{default: 8'd0};
      count        <= 3'd0;
      pend_cnt     <= 3'd0;
      pend_is_stat <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // ---------------- output register and pending results ----------------
      if (pend_pop) begin
        out_valid <= 1'b1;
        if (pend_is_stat) begin
          out_byte     <= 8'd0;
          byte_valid   <= 1'b0;
          out_last     <= 1'b1;
          frame_status <= pend_status;
        end else begin
          out_byte     <= pend_word[31:24];
          byte_valid   <= 1'b1;
          out_last     <= (pend_cnt == 3'd1);
          frame_status <= STAT_OK;
          pend_word    <= {pend_word[23:0], 8'd0};
        end
        pend_cnt <= pend_cnt - 3'd1;
      end else if (accept && !check_mode) begin
        // append: byte passes through, crc bytes queue behind it on the final byte
        out_valid    <= 1'b1;
        out_byte     <= data_byte;
        byte_valid   <= 1'b1;
        out_last     <= 1'b0;
        frame_status <= STAT_OK;
        if (last_byte) begin
          pend_cnt     <= 3'd4;
          pend_is_stat <= 1'b0;
          pend_word    <= crc_fin;
        end
      end else if (accept && full) begin
        // check: oldest byte leaves as payload, status follows on the final byte
        out_valid    <= 1'b1;
        out_byte     <= delay[0];
        byte_valid   <= 1'b1;
        out_last     <= 1'b0;
        frame_status <= STAT_OK;
        if (last_byte) begin
          pend_cnt     <= 3'd1;
          pend_is_stat <= 1'b1;
          pend_status  <= chk_status;
        end
      end else if (accept && last_byte) begin
        // check: frame ends before any payload left, status only
        out_valid    <= 1'b1;
        out_byte     <= 8'd0;
        byte_valid   <= 1'b0;
        out_last     <= 1'b1;
        frame_status <= chk_status;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // ---------------- frame state ----------------
      if (cfg_wr_en) begin
        // a mode write, even of the same mode, drops any partial frame
        check_mode <= cfg_wr_data;
        crc        <= CRC_INIT;
        delay      <= '{default: 8'd0};
        count      <= 3'd0;
      end else if (accept) begin
        if (last_byte) begin
          crc   <= CRC_INIT;
          delay <= '{default: 8'd0};
          count <= 3'd0;
        end else if (!check_mode) begin
          crc <= crc_app;
        end else begin
          crc      <= crc_chk;
          delay[0] <= delay[1];
          delay[1] <= delay[2];
          delay[2] <= delay[3];
          delay[3] <= data_byte;
          count    <= count_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/crcfac_checker.sv
// port-level checker for the crc-32 framer, bound to the framer module
`default_nettype none

module crcfac_checker
  import crcfac_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       out_last,
  input wire logic [1:0] frame_status
);

  // a stalled output request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(byte_valid) && $stable(frame_status))
    else $error("output request changed while stalled");

  // a status-only request always closes a frame
  a_stat_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_last)
    else $error("status request without frame end");

  // an error status only rides on a status-only frame end
  a_err_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_status == STAT_BAD || frame_status == STAT_SHORT)
      |-> out_last && !byte_valid)
    else $error("error status on a data request");

  // a frame ending on a data byte (appended crc) reports ok
  a_app_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last && byte_valid |-> frame_status == STAT_OK)
    else $error("appended crc end with non-ok status");

endmodule

bind crc32_frame_append_check crcfac_checker u_crcfac_checker (.*);

`default_nettype wire

// File: tb/sv/tb.sv
// self-checking testbench for the crc-32 frame append / check block
`timescale 1ns / 100ps

module tb;
  import crcfac_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;    // covers the output register and the crc trailer hold
  localparam int unsigned RANDOM_BYTES = 200;
  localparam int unsigned MAX_PRINTED  = 40;

  // one request on the input side: a frame byte and its last mark
  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  // one request on the output side
  typedef struct {
    logic [7:0]    data;
    logic          carries;
    logic          last;
    frame_status_t status;
  } out_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  logic [1:0] frame_status;

  crc32_frame_append_check dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .out_last     (out_last),
    .frame_status (frame_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // pending frame bytes and the results they are predicted to give
  byte_req_t   pend_q[$];
  out_req_t    result_q[$];

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_pushed = 0;
  int unsigned n_taken = 0;
  int unsigned n_results = 0;
  int unsigned n_append_frames = 0;
  int unsigned n_ok = 0;
  int unsigned n_bad = 0;
  int unsigned n_short = 0;

  // handshake flags, set at the rising edge and read at the falling edge
  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  logic        no_idle = 1'b0;

  // framer state as the testbench sees it
  logic        mode_chk;
  logic [31:0] crc_run;
  logic [7:0]  hold [4];
  int unsigned held;

  // reflected crc-32, one bit at a time, lsb of the byte first
  function automatic logic [31:0] crc_byte_step(input logic [31:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic int unsigned draw_wait();
    if (no_idle) begin
      return 0;
    end
    if ($urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s", cycles, msg);
    end
  endtask

  task automatic clear_frame_state();
    crc_run = CRC_INIT;
    for (int i = 0; i < 4; i++) begin
      hold[i] = 8'h00;
    end
    held = 0;
  endtask

  task automatic push_result(input logic [7:0] b, input logic carries, input logic lst,
                             input frame_status_t st);
    out_req_t item;
    item.data    = b;
    item.carries = carries;
    item.last    = lst;
    item.status  = st;
    result_q = {result_q, item};
  endtask

  // works out every result that one accepted frame byte gives
  task automatic predict_framer(input logic [7:0] b, input logic lst);
    logic [31:0]   fin;
    logic [31:0]   trailer;
    frame_status_t st;
    if (!mode_chk) begin
      push_result(b, 1'b1, 1'b0, STAT_OK);
      crc_run = crc_byte_step(crc_run, b);
      if (lst) begin
        fin = ~crc_run;
        push_result(fin[31:24], 1'b1, 1'b0, STAT_OK);
        push_result(fin[23:16], 1'b1, 1'b0, STAT_OK);
        push_result(fin[15:8], 1'b1, 1'b0, STAT_OK);
        push_result(fin[7:0], 1'b1, 1'b1, STAT_OK);
        n_append_frames++;
        clear_frame_state();
      end
    end else begin
      // oldest held byte leaves as payload once the delay line is full
      if (held >= 4) begin
        push_result(hold[0], 1'b1, 1'b0, STAT_OK);
        crc_run = crc_byte_step(crc_run, hold[0]);
      end
      hold[0] = hold[1];
      hold[1] = hold[2];
      hold[2] = hold[3];
      hold[3] = b;
      if (held < 4) begin
        held++;
      end
      if (lst) begin
        if (held < 4) begin
          st = STAT_SHORT;
          n_short++;
        end else begin
          trailer = {hold[0], hold[1], hold[2], hold[3]};
          if (trailer == ~crc_run) begin
            st = STAT_OK;
            n_ok++;
          end else begin
            st = STAT_BAD;
            n_bad++;
          end
        end
        push_result(8'h00, 1'b0, 1'b1, st);
        clear_frame_state();
      end
    end
  endtask

  // monitor: everything sampled at the rising edge
  always @(posedge clk) begin
    out_req_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               result_q.size());
      $display("tb NOT OK");
      $finish;
    end else begin
      in_took  = 1'b0;
      out_took = 1'b0;
      if (!rst) begin
        // any register write restarts the frame
        if (cfg_wr_en) begin
          mode_chk = cfg_wr_data;
          clear_frame_state();
        end
        if (in_valid && in_ready) begin
          in_took = 1'b1;
          n_taken++;
          predict_framer(data_byte, last_byte);
        end
        if (out_valid === 1'b1 && out_ready) begin
          out_took = 1'b1;
          n_results++;
          if (result_q.size() == 0) begin
            report_mismatch($sformatf("unexpected request byte %h valid %b last %b status %0d",
                                      out_byte, byte_valid, out_last, frame_status));
          end else begin
            want = result_q.pop_front();
            if (out_byte !== want.data || byte_valid !== want.carries ||
                out_last !== want.last || frame_status !== want.status) begin
              report_mismatch($sformatf(
                "got byte %h valid %b last %b status %0d, want %h %b %b %0d",
                out_byte, byte_valid, out_last, frame_status,
                want.data, want.carries, want.last, want.status));
            end
          end
        end
      end
    end
  end

  // input driver: next byte from the pending queue after a random gap
  always @(negedge clk) begin
    logic [7:0] d;
    logic       v;
    logic       l;
    byte_req_t  r;
    v = in_valid;
    d = data_byte;
    l = last_byte;
    if (rst) begin
      v = 1'b0;
    end else begin
      if (v && in_took) begin
        v = 1'b0;
        in_wait = draw_wait();
      end
      if (!v) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (pend_q.size() > 0) begin
          r = pend_q.pop_front();
          v = 1'b1;
          d = r.data;
          l = r.last;
        end
      end
    end
    // single assignment per signal in this step
    in_valid  <= v;
    data_byte <= d;
    last_byte <= l;
  end

  // output side: ready drops for a random stall, possibly none, after each accepted result
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) begin
        out_wait = draw_wait();
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_frame(input logic [7:0] bytes[$], input bit terminate);
    byte_req_t r;
    foreach (bytes[i]) begin
      r.data = bytes[i];
      r.last = terminate && (i == bytes.size() - 1);
      pend_q = {pend_q, r};
      n_pushed++;
    end
  endtask

  // appends the big-endian crc trailer of the bytes already queued
  task automatic add_trailer(ref logic [7:0] bytes[$]);
    logic [31:0] c;
    c = CRC_INIT;
    foreach (bytes[i]) begin
      c = crc_byte_step(c, bytes[i]);
    end
    c = ~c;
    bytes = {bytes, c[31:24], c[23:16], c[15:8], c[7:0]};
  endtask

  // waits until every byte is taken and every result has come, then lets the block settle
  task automatic drain();
    while (n_taken != n_pushed || result_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register written only while the block is idle
  task automatic set_mode(input logic chk);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= chk;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0]  q[$];
    logic        m;
    int unsigned nframes;
    int unsigned len;
    int unsigned kind;
    int unsigned idx;
    int unsigned start;

    mode_chk = 1'b0;
    clear_frame_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // append mode: one-byte frame, byte extremes, and a frame cut by a write
    set_mode(1'b0);
    q = '{8'h00};
    send_frame(q, 1'b1);
    q = '{8'hFF, 8'h80};
    send_frame(q, 1'b1);
    q = '{8'h5A};
    send_frame(q, 1'b0);

    // check mode: too short frames of one and three bytes
    set_mode(1'b1);
    q = '{8'hAA};
    send_frame(q, 1'b1);
    q = '{8'h01, 8'h02, 8'h03};
    send_frame(q, 1'b1);
    // empty payload, trailer zero matches, all ones does not
    q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(q, 1'b1);
    q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(q, 1'b1);
    // one payload byte with a good trailer
    q = '{8'h55};
    add_trailer(q);
    send_frame(q, 1'b1);
    // frame dropped by rewriting the same mode
    q = '{8'h3C, 8'hC3};
    send_frame(q, 1'b0);
    set_mode(1'b1);

    // random phases, mostly well-formed frames
    start = n_pushed;
    while (n_pushed - start < RANDOM_BYTES) begin
      m = 1'($urandom_range(0, 1));
      no_idle = ($urandom_range(0, 3) == 0);
      set_mode(m);
      nframes = $urandom_range(2, 5);
      repeat (nframes) begin
        q.delete();
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 8);
        kind = $urandom_range(0, 9);
        if (!m) begin
          repeat (len + 1) q = {q, rand_byte()};
        end else if (kind == 8) begin
          repeat ($urandom_range(1, 3)) q = {q, rand_byte()};
        end else if (kind == 9) begin
          // noise: random bytes, trailer almost never right
          repeat ($urandom_range(1, 12)) q = {q, rand_byte()};
        end else begin
          repeat (len) q = {q, rand_byte()};
          add_trailer(q);
          // corrupt one bit somewhere in payload or trailer
          if (kind >= 6) begin
            idx = $urandom_range(0, q.size() - 1);
            q[idx] = q[idx] ^ (8'h01 << $urandom_range(0, 7));
          end
        end
        send_frame(q, 1'b1);
      end
      // sometimes leave a frame open for the next register write to drop
      if ($urandom_range(0, 4) == 0) begin
        q.delete();
        repeat ($urandom_range(1, 6)) q = {q, rand_byte()};
        send_frame(q, 1'b0);
      end
    end

    drain();
    if (result_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never came", result_q.size()));
    end
    $display("sent %0d bytes, checked %0d results over %0d cycles", n_pushed, n_results,
             cycles);
    $display("append frames %0d, check frames ok %0d, bad crc %0d, too short %0d",
             n_append_frames, n_ok, n_bad, n_short);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/crcfac_pkg.sv
rtl/core/crc32_frame_append_check.sv
rtl/core/crcfac_checker.sv
tb/sv/tb.sv
